// ----- src/assert_macros.svh -----
// Assertion macros shared by the checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ----- src/pdse_pkg.sv -----
// ----------------------------------------------------------------------------
// pdse_pkg
// Types, codes and constants of the PCI device search engine.
// ----------------------------------------------------------------------------
package pdse_pkg;

    localparam int NUM_BUSES_DEF = 256;
    localparam int NUM_SLOTS_DEF = 32;
    localparam int NUM_FUNCS_DEF = 8;

    localparam int ADDR_W = 3;

    // register indexes, taken from paddr[2]
    localparam logic REG_VENDOR = 1'b0;
    localparam logic REG_DEVICE = 1'b1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_RESP  = 1'b1;

    localparam logic [1:0] KIND_READ      = 2'd0;
    localparam logic [1:0] KIND_FOUND     = 2'd1;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

    localparam logic [7:0] OFF_ID     = 8'h00;
    localparam logic [7:0] OFF_CLASS  = 8'h08;
    localparam logic [7:0] OFF_HEADER = 8'h0C;
    localparam logic [7:0] OFF_BAR0   = 8'h10;
    localparam logic [7:0] OFF_IRQ    = 8'h3C;

    localparam logic [15:0] VID_ABSENT = 16'hFFFF;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_ID     = 6'b000010,
        PH_CLASS  = 6'b000100,
        PH_IRQ    = 6'b001000,
        PH_BAR    = 6'b010000,
        PH_HEADER = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] bus;
        logic [4:0] slot;
        logic [2:0] func;
        logic [7:0] saved_class;
        logic [7:0] saved_subclass;
        logic [7:0] saved_irq;
    } scan_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  hit_bus;
        logic [4:0]  hit_slot;
        logic [2:0]  hit_function;
        logic [7:0]  hit_class;
        logic [7:0]  hit_subclass;
        logic [7:0]  hit_irq;
        logic [31:0] hit_bar;
    } result_t;

endpackage

// ----- src/pdse_cfg.sv -----
// ----------------------------------------------------------------------------
// pdse_cfg
// APB register file holding the target vendor and device IDs.
// ----------------------------------------------------------------------------
module pdse_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdse_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [15:0]                 target_vendor,
    output logic [15:0]                 target_device
);

    logic [15:0] vendor_reg;
    logic [15:0] device_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_reg <= '0;
            device_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                pdse_pkg::REG_VENDOR: vendor_reg <= pwdata[15:0];
                pdse_pkg::REG_DEVICE: device_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            pdse_pkg::REG_VENDOR: prdata = {16'd0, vendor_reg};
            pdse_pkg::REG_DEVICE: prdata = {16'd0, device_reg};
            default:              prdata = '0;
        endcase
    end

    assign target_vendor = vendor_reg;
    assign target_device = device_reg;

endmodule

// ----- src/pdse_step.sv -----
// ----------------------------------------------------------------------------
// pdse_step
// Next-state and result logic of the scan for one beat.
// ----------------------------------------------------------------------------
module pdse_step #(
    parameter int NUM_BUSES = pdse_pkg::NUM_BUSES_DEF,
    parameter int NUM_SLOTS = pdse_pkg::NUM_SLOTS_DEF,
    parameter int NUM_FUNCS = pdse_pkg::NUM_FUNCS_DEF
) (
    input  pdse_pkg::scan_state_t st,
    input  logic                  req_type,
    input  logic [31:0]           read_data,
    input  logic [15:0]           target_vendor,
    input  logic [15:0]           target_device,
    output pdse_pkg::scan_state_t st_next,
    output logic                  has_result,
    output pdse_pkg::result_t     res
);

    logic       go_func;
    logic       go_slot;
    logic       issue;
    logic [7:0] offset;
    logic       last_func;
    logic       last_slot;
    logic       last_bus;

    assign last_func = ({1'b0, st.func} + 4'd1) >= 4'(NUM_FUNCS);
    assign last_slot = ({1'b0, st.slot} + 6'd1) >= 6'(NUM_SLOTS);
    assign last_bus  = ({1'b0, st.bus} + 9'd1) >= 9'(NUM_BUSES);

    always_comb
    begin
        st_next    = st;
        res        = '0;
        has_result = 1'b0;
        issue      = 1'b0;
        offset     = pdse_pkg::OFF_ID;
        go_func    = 1'b0;
        go_slot    = 1'b0;

        if (req_type == pdse_pkg::REQ_START)
        begin
            st_next.bus            = '0;
            st_next.slot           = '0;
            st_next.func           = '0;
            st_next.saved_class    = '0;
            st_next.saved_subclass = '0;
            st_next.saved_irq      = '0;
            st_next.phase          = pdse_pkg::PH_ID;
            issue                  = 1'b1;
        end
        else
        begin
            unique case (st.phase)
                pdse_pkg::PH_ID:
                begin
                    if (read_data[15:0] == pdse_pkg::VID_ABSENT)
                    begin
                        go_slot = (st.func == 3'd0);
                        go_func = (st.func != 3'd0);
                    end
                    else if (read_data[15:0] == target_vendor &&
                             read_data[31:16] == target_device)
                    begin
                        issue         = 1'b1;
                        offset        = pdse_pkg::OFF_CLASS;
                        st_next.phase = pdse_pkg::PH_CLASS;
                    end
                    else if (st.func == 3'd0)
                    begin
                        issue         = 1'b1;
                        offset        = pdse_pkg::OFF_HEADER;
                        st_next.phase = pdse_pkg::PH_HEADER;
                    end
                    else
                    begin
                        go_func = 1'b1;
                    end
                end
                pdse_pkg::PH_HEADER:
                begin
                    // header bit 7 clear: single-function device
                    go_slot = !read_data[23];
                    go_func = read_data[23];
                end
                pdse_pkg::PH_CLASS:
                begin
                    st_next.saved_class    = read_data[31:24];
                    st_next.saved_subclass = read_data[23:16];
                    issue                  = 1'b1;
                    offset                 = pdse_pkg::OFF_IRQ;
                    st_next.phase          = pdse_pkg::PH_IRQ;
                end
                pdse_pkg::PH_IRQ:
                begin
                    st_next.saved_irq = read_data[7:0];
                    issue             = 1'b1;
                    offset            = pdse_pkg::OFF_BAR0;
                    st_next.phase     = pdse_pkg::PH_BAR;
                end
                pdse_pkg::PH_BAR:
                begin
                    has_result       = 1'b1;
                    res.kind         = pdse_pkg::KIND_FOUND;
                    res.hit_bus      = st.bus;
                    res.hit_slot     = st.slot;
                    res.hit_function = st.func;
                    res.hit_class    = st.saved_class;
                    res.hit_subclass = st.saved_subclass;
                    res.hit_irq      = st.saved_irq;
                    res.hit_bar      = read_data;
                    st_next.phase    = pdse_pkg::PH_IDLE;
                end
                default: ;  // idle: response dropped
            endcase
        end

        // walk to the next function, rolling over into the next slot
        if (go_func)
        begin
            if (last_func)
            begin
                go_slot = 1'b1;
            end
            else
            begin
                st_next.func  = st.func + 3'd1;
                st_next.phase = pdse_pkg::PH_ID;
                issue         = 1'b1;
            end
        end

        if (go_slot)
        begin
            st_next.func = '0;
            if (last_slot)
            begin
                st_next.slot = '0;
                if (last_bus)
                begin
                    has_result    = 1'b1;
                    res.kind      = pdse_pkg::KIND_NOT_FOUND;
                    st_next.phase = pdse_pkg::PH_IDLE;
                end
                else
                begin
                    st_next.bus   = st.bus + 8'd1;
                    st_next.phase = pdse_pkg::PH_ID;
                    issue         = 1'b1;
                end
            end
            else
            begin
                st_next.slot  = st.slot + 5'd1;
                st_next.phase = pdse_pkg::PH_ID;
                issue         = 1'b1;
            end
        end

        if (issue)
        begin
            has_result  = 1'b1;
            res.kind    = pdse_pkg::KIND_READ;
            res.address = {1'b1, 7'd0, st_next.bus, st_next.slot, st_next.func,
                           offset[7:2], 2'b00};
        end
    end

endmodule

// ----- src/pci_device_search_engine.sv -----
// ----------------------------------------------------------------------------
// pci_device_search_engine
// Walks PCI configuration space for a function with a given vendor/device ID.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): req_type 0 starts the scan at bus 0,
//   slot 0, function 0; req_type 1 carries read_data answering the previous
//   read request. Output channel (out_valid/out_stall): one beat per input
//   beat that has a result - a read request (request_address), found with
//   the hit_ fields, or not found. A response while idle gives no beat.
//   Targets are written over APB: target_vendor at 0x0, target_device at 0x4.
//   Pipeline: an accepted beat is held in the input register, then processed
//   by the step logic into the result register, which drives the outputs.
//   Throughput: one beat per cycle while the receiver does not stall, set by
//   the single input register feeding the step logic and the result register.
//   Reset: scan idle, position zero, targets zero, both registers empty.
//   Receiver stall: the result is held; one more input beat is taken into the
//   input register, after which in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module pci_device_search_engine #(
    parameter int NUM_BUSES = pdse_pkg::NUM_BUSES_DEF,
    parameter int NUM_SLOTS = pdse_pkg::NUM_SLOTS_DEF,
    parameter int NUM_FUNCS = pdse_pkg::NUM_FUNCS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdse_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [31:0]                 read_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  result_kind,
    output logic [31:0]                 request_address,
    output logic [7:0]                  hit_bus,
    output logic [4:0]                  hit_slot,
    output logic [2:0]                  hit_function,
    output logic [7:0]                  hit_class,
    output logic [7:0]                  hit_subclass,
    output logic [7:0]                  hit_irq,
    output logic [31:0]                 hit_bar
);

    logic [15:0] target_vendor;
    logic [15:0] target_device;

    logic        in_valid_reg;
    logic        in_type_reg;
    logic [31:0] in_data_reg;
    logic        out_valid_reg;

    pdse_pkg::scan_state_t st_reg;
    pdse_pkg::scan_state_t st_next;
    pdse_pkg::result_t     res_next;
    pdse_pkg::result_t     res_reg;
    logic                  has_result;

    logic out_free;
    logic advance;
    logic in_accept;

    pdse_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .target_vendor (target_vendor),
        .target_device (target_device)
    );

    pdse_step #(
        .NUM_BUSES (NUM_BUSES),
        .NUM_SLOTS (NUM_SLOTS),
        .NUM_FUNCS (NUM_FUNCS)
    ) u_step (
        .st            (st_reg),
        .req_type      (in_type_reg),
        .read_data     (in_data_reg),
        .target_vendor (target_vendor),
        .target_device (target_device),
        .st_next       (st_next),
        .has_result    (has_result),
        .res           (res_next)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_type_reg <= req_type;
            in_data_reg <= read_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: pdse_pkg::PH_IDLE, default: '0};
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = res_reg.kind;
    assign request_address = res_reg.address;
    assign hit_bus         = res_reg.hit_bus;
    assign hit_slot        = res_reg.hit_slot;
    assign hit_function    = res_reg.hit_function;
    assign hit_class       = res_reg.hit_class;
    assign hit_subclass    = res_reg.hit_subclass;
    assign hit_irq         = res_reg.hit_irq;
    assign hit_bar         = res_reg.hit_bar;

endmodule

// ----- src/pdse_checker.sv -----
// ----------------------------------------------------------------------------
// pdse_checker
// Port-level checks of the search engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_kind,
    input logic [31:0] request_address,
    input logic [7:0]  hit_bus,
    input logic [4:0]  hit_slot,
    input logic [2:0]  hit_function,
    input logic [7:0]  hit_class,
    input logic [7:0]  hit_subclass,
    input logic [7:0]  hit_irq,
    input logic [31:0] hit_bar
);

    logic read_beat;
    logic final_beat;
    logic miss_beat;
    logic read_ok;
    logic hits_zero;

    assign read_beat  = out_valid && result_kind == pdse_pkg::KIND_READ;
    assign final_beat = out_valid && result_kind != pdse_pkg::KIND_READ;
    assign miss_beat  = out_valid && result_kind != pdse_pkg::KIND_FOUND;
    assign read_ok    = request_address[31] && request_address[30:24] == 7'd0 &&
                        request_address[1:0] == 2'd0;
    assign hits_zero  = hit_bus == 8'd0 && hit_slot == 5'd0 && hit_function == 3'd0 &&
                        hit_class == 8'd0 && hit_subclass == 8'd0 && hit_irq == 8'd0 &&
                        hit_bar == 32'd0;

    `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid, "beat dropped")

    `ASSERT_IMPL(a_read_form, clk, rst_n, read_beat, read_ok, "malformed read request")

    `ASSERT_IMPL(a_no_addr, clk, rst_n, final_beat, request_address == 32'd0, "address on result")

    `ASSERT_IMPL(a_hit_clear, clk, rst_n, miss_beat, hits_zero, "hit fields set without a match")

endmodule

bind pci_device_search_engine pdse_checker u_checker (.*);
